### sv/macd_pkg.sv
package macd_pkg;

    localparam int MAX_PERIOD = 255;
    localparam int COUNT_MAX  = 2 * MAX_PERIOD + 1;
    localparam int COUNT_W    = $clog2(COUNT_MAX + 1);

    localparam int PRICE_W    = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int AVG_W      = PRICE_W + FRAC_SHIFT;
    localparam int PERIOD_W   = 8;
    localparam int ALPHA_W    = 16;
    localparam int SEED_W     = 40;
    localparam int SIG_SEED_W = 56;
    localparam int DIFF_W     = AVG_W + 1;
    localparam int PROD_W     = DIFF_W + ALPHA_W;
    localparam int DIVIDEND_W = SEED_W + FRAC_SHIFT;
    localparam int MUL_STEPS  = ALPHA_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_PERIOD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_ALPHA    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_ALPHA    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_ALPHA  = 3'd5;

    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 8'd12;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 8'd26;
    localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;
    localparam logic [ALPHA_W-1:0]  FAST_ALPHA_RST    = 16'd10082;
    localparam logic [ALPHA_W-1:0]  SLOW_ALPHA_RST    = 16'd4855;
    localparam logic [ALPHA_W-1:0]  SIGNAL_ALPHA_RST  = 16'd13107;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               start_series;
    } macd_in_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] macd_value;
        logic signed [AVG_W-1:0] signal_value;
        logic signed [AVG_W-1:0] histogram_value;
        logic                    macd_valid;
        logic                    signal_valid;
    } macd_out_t;

    typedef struct packed {
        logic                     start;
        logic                     divide;
        logic signed [DIFF_W-1:0] mcand;
        logic [ALPHA_W-1:0]       mplier;
        logic [DIVIDEND_W-1:0]    dividend;
        logic [PERIOD_W-1:0]      divisor;
    } macd_unit_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIFF_W-1:0] product;
        logic [DIVIDEND_W-1:0]    quotient;
    } macd_unit_rsp_t;

endpackage

### sv/macd_iter_unit.sv
module macd_iter_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  macd_pkg::macd_unit_req_t req,
    output macd_pkg::macd_unit_rsp_t rsp
);
    import macd_pkg::*;

    logic                     active_reg, active_next;
    logic                     done_reg, done_next;
    logic                     divide_reg, divide_next;
    logic [STEP_W-1:0]        count_reg, count_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [DIFF_W-1:0] mcand_reg, mcand_next;
    logic [ALPHA_W-1:0]       mplier_reg, mplier_next;
    logic [DIVIDEND_W-1:0]    quo_reg, quo_next;
    logic [PERIOD_W-1:0]      rem_reg, rem_next;
    logic [PERIOD_W-1:0]      divisor_reg, divisor_next;

    logic [PERIOD_W:0]        rem_shift;
    logic [PERIOD_W:0]        rem_diff;
    logic                     rem_fits;
    logic signed [PROD_W-1:0] addend;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign rem_fits  = rem_shift >= {1'b0, divisor_reg};
    assign addend    = mplier_reg[ALPHA_W-1]
                     ? {{(PROD_W-DIFF_W){mcand_reg[DIFF_W-1]}}, mcand_reg}
                     : '0;

    always_comb
    begin
        active_next  = active_reg;
        done_next    = 1'b0;
        divide_next  = divide_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            active_next  = 1'b1;
            divide_next  = req.divide;
            count_next   = req.divide ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MUL_STEPS - 1);
            acc_next     = '0;
            mcand_next   = req.mcand;
            mplier_next  = req.mplier;
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (active_reg)
        begin
            if (divide_reg)
            begin
                rem_next = rem_fits ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], rem_fits};
            end
            else
            begin
                acc_next    = {acc_reg[PROD_W-2:0], 1'b0} + addend;
                mplier_next = {mplier_reg[ALPHA_W-2:0], 1'b0};
            end
            if (count_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divide_reg  <= divide_next;
        count_reg   <= count_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.product  = acc_reg[PROD_W-1:ALPHA_W];
    assign rsp.quotient = quo_reg;

endmodule

### sv/macd_triple_ema_stream.sv
// Channel  | Signals                                   | Transfer
// ---------+-------------------------------------------+-------------------------------
// sample   | sample_valid, sample_ready, sample        | one price in per transfer
// result   | result_valid, result_ready, result        | one MACD result per sample
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// An accepted sample updates each of the three averages that has work by its smoothing factor,
// or by a seed division in place of that update when the average's period is first reached.
// All multiplies and seed divisions go through one shift-add and restoring-divide unit
// that retires one bit per cycle.
// Reset clears the registers to their defaults and the running series to zero.
// A stalled result waits in the output register while the next sample is worked on.
module macd_triple_ema_stream (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  macd_pkg::macd_in_t                   sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output macd_pkg::macd_out_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [macd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [macd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import macd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FAST   = 3'd1;
    localparam logic [2:0] S_FAST_W = 3'd2;
    localparam logic [2:0] S_SLOW   = 3'd3;
    localparam logic [2:0] S_SLOW_W = 3'd4;
    localparam logic [2:0] S_MACD   = 3'd5;
    localparam logic [2:0] S_SIG_W  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] r;
        r = p;
        if (p == '0)
            r = PERIOD_W'(1);
        else if (32'(p) > MAX_PERIOD)
            r = PERIOD_W'(MAX_PERIOD);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (32'(c) >= COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic signed [AVG_W-1:0] sat48(input logic signed [DIFF_W-1:0] v);
        logic signed [AVG_W-1:0] r;
        r = v[AVG_W-1:0];
        if (v[DIFF_W-1] != v[AVG_W-1])
            r = v[DIFF_W-1] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
        return r;
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [PERIOD_W-1:0]      fast_period_reg, slow_period_reg, signal_period_reg;
    logic [ALPHA_W-1:0]       fast_alpha_reg, slow_alpha_reg, signal_alpha_reg;

    logic [AVG_W-1:0]         fast_avg_reg, fast_avg_next;
    logic [AVG_W-1:0]         slow_avg_reg, slow_avg_next;
    logic signed [AVG_W-1:0]  sig_avg_reg, sig_avg_next;
    logic [SEED_W-1:0]        fast_sum_reg, fast_sum_next;
    logic [SEED_W-1:0]        slow_sum_reg, slow_sum_next;
    logic signed [SIG_SEED_W-1:0] sig_sum_reg, sig_sum_next;
    logic [COUNT_W-1:0]       sample_count_reg, sample_count_next;
    logic [COUNT_W-1:0]       macd_count_reg, macd_count_next;

    logic [PRICE_W-1:0]       price_reg, price_next;
    logic signed [AVG_W-1:0]  macd_reg, macd_next;
    macd_out_t                result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    macd_unit_req_t           unit_req;
    macd_unit_rsp_t           unit_rsp;

    logic [PERIOD_W-1:0]      fp, sp, gp;
    logic [COUNT_W-1:0]       fp_c, sp_c, gp_c;
    logic [AVG_W-1:0]         price_q;
    logic [SEED_W-1:0]        fast_sum_add, slow_sum_add;
    logic signed [DIFF_W-1:0] fast_mcand, slow_mcand, sig_mcand;
    logic signed [DIFF_W-1:0] fast_upd, slow_upd, sig_upd;
    logic signed [DIFF_W-1:0] macd_diff, hist_diff;
    logic signed [AVG_W-1:0]  macd_sat;
    logic [COUNT_W-1:0]       mc_inc;
    logic [COUNT_W-1:0]       count_base;
    logic signed [SIG_SEED_W-1:0] sig_sum_add, sig_abs;
    logic [AVG_W-1:0]         quo48;
    logic                     macd_ok, signal_ok;

    assign fp   = eff_period(fast_period_reg);
    assign sp   = eff_period(slow_period_reg);
    assign gp   = eff_period(signal_period_reg);
    assign fp_c = COUNT_W'(fp);
    assign sp_c = COUNT_W'(sp);
    assign gp_c = COUNT_W'(gp);

    assign price_q      = {price_reg, {FRAC_SHIFT{1'b0}}};
    assign fast_sum_add = fast_sum_reg + SEED_W'(price_reg);
    assign slow_sum_add = slow_sum_reg + SEED_W'(price_reg);
    assign fast_mcand   = $signed({1'b0, price_q}) - $signed({1'b0, fast_avg_reg});
    assign slow_mcand   = $signed({1'b0, price_q}) - $signed({1'b0, slow_avg_reg});
    assign fast_upd     = $signed({1'b0, fast_avg_reg}) + unit_rsp.product;
    assign slow_upd     = $signed({1'b0, slow_avg_reg}) + unit_rsp.product;
    assign sig_upd      = {sig_avg_reg[AVG_W-1], sig_avg_reg} + unit_rsp.product;

    assign macd_diff   = $signed({1'b0, fast_avg_reg}) - $signed({1'b0, slow_avg_reg});
    assign macd_sat    = sat48(macd_diff);
    assign mc_inc      = sat_inc(macd_count_reg);
    assign sig_sum_add = sig_sum_reg
                       + {{(SIG_SEED_W-AVG_W){macd_sat[AVG_W-1]}}, macd_sat};
    assign sig_abs     = sig_sum_add[SIG_SEED_W-1] ? -sig_sum_add : sig_sum_add;
    assign sig_mcand   = {macd_sat[AVG_W-1], macd_sat} - {sig_avg_reg[AVG_W-1], sig_avg_reg};
    assign quo48       = unit_rsp.quotient[AVG_W-1:0];

    assign hist_diff   = {macd_reg[AVG_W-1], macd_reg} - {sig_avg_reg[AVG_W-1], sig_avg_reg};
    assign macd_ok     = sample_count_reg >= sp_c;
    assign signal_ok   = macd_ok && (macd_count_reg >= gp_c);
    assign count_base  = sample.start_series ? '0 : sample_count_reg;

    macd_iter_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        fast_avg_next     = fast_avg_reg;
        slow_avg_next     = slow_avg_reg;
        sig_avg_next      = sig_avg_reg;
        fast_sum_next     = fast_sum_reg;
        slow_sum_next     = slow_sum_reg;
        sig_sum_next      = sig_sum_reg;
        sample_count_next = sample_count_reg;
        macd_count_next   = macd_count_reg;
        price_next        = price_reg;
        macd_next         = macd_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unit_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    price_next        = sample.price;
                    sample_count_next = sat_inc(count_base);
                    if (sample.start_series)
                    begin
                        fast_avg_next   = '0;
                        slow_avg_next   = '0;
                        sig_avg_next    = '0;
                        fast_sum_next   = '0;
                        slow_sum_next   = '0;
                        sig_sum_next    = '0;
                        macd_count_next = '0;
                    end
                    state_next = S_FAST;
                end
            end
            S_FAST:
            begin
                if (sample_count_reg < fp_c)
                begin
                    fast_sum_next = fast_sum_add;
                    state_next    = S_SLOW;
                end
                else if (sample_count_reg == fp_c)
                begin
                    fast_sum_next     = fast_sum_add;
                    unit_req.start    = 1'b1;
                    unit_req.divide   = 1'b1;
                    unit_req.dividend = {fast_sum_add, {FRAC_SHIFT{1'b0}}};
                    unit_req.divisor  = fp;
                    state_next        = S_FAST_W;
                end
                else
                begin
                    unit_req.start  = 1'b1;
                    unit_req.mcand  = fast_mcand;
                    unit_req.mplier = fast_alpha_reg;
                    state_next      = S_FAST_W;
                end
            end
            S_FAST_W:
            begin
                if (unit_rsp.done)
                begin
                    fast_avg_next = (sample_count_reg == fp_c) ? quo48 : fast_upd[AVG_W-1:0];
                    state_next    = S_SLOW;
                end
            end
            S_SLOW:
            begin
                if (sample_count_reg < sp_c)
                begin
                    slow_sum_next = slow_sum_add;
                    state_next    = S_MACD;
                end
                else if (sample_count_reg == sp_c)
                begin
                    slow_sum_next     = slow_sum_add;
                    unit_req.start    = 1'b1;
                    unit_req.divide   = 1'b1;
                    unit_req.dividend = {slow_sum_add, {FRAC_SHIFT{1'b0}}};
                    unit_req.divisor  = sp;
                    state_next        = S_SLOW_W;
                end
                else
                begin
                    unit_req.start  = 1'b1;
                    unit_req.mcand  = slow_mcand;
                    unit_req.mplier = slow_alpha_reg;
                    state_next      = S_SLOW_W;
                end
            end
            S_SLOW_W:
            begin
                if (unit_rsp.done)
                begin
                    slow_avg_next = (sample_count_reg == sp_c) ? quo48 : slow_upd[AVG_W-1:0];
                    state_next    = S_MACD;
                end
            end
            S_MACD:
            begin
                if (macd_ok)
                begin
                    macd_next       = macd_sat;
                    macd_count_next = mc_inc;
                    if (mc_inc < gp_c)
                    begin
                        sig_sum_next = sig_sum_add;
                        state_next   = S_OUT;
                    end
                    else if (mc_inc == gp_c)
                    begin
                        sig_sum_next      = sig_sum_add;
                        unit_req.start    = 1'b1;
                        unit_req.divide   = 1'b1;
                        unit_req.dividend = DIVIDEND_W'(sig_abs);
                        unit_req.divisor  = gp;
                        state_next        = S_SIG_W;
                    end
                    else
                    begin
                        unit_req.start  = 1'b1;
                        unit_req.mcand  = sig_mcand;
                        unit_req.mplier = signal_alpha_reg;
                        state_next      = S_SIG_W;
                    end
                end
                else
                begin
                    macd_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_SIG_W:
            begin
                if (unit_rsp.done)
                begin
                    if (macd_count_reg == gp_c)
                        sig_avg_next = sig_sum_reg[SIG_SEED_W-1] ? -$signed(quo48)
                                                                 : $signed(quo48);
                    else
                        sig_avg_next = sig_upd[AVG_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.macd_valid      = macd_ok;
                    result_next.signal_valid    = signal_ok;
                    result_next.macd_value      = macd_ok ? macd_reg : '0;
                    result_next.signal_value    = signal_ok ? sig_avg_reg : '0;
                    result_next.histogram_value = signal_ok ? sat48(hist_diff) : '0;
                    result_valid_next           = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            result_valid_reg  <= 1'b0;
            fast_avg_reg      <= '0;
            slow_avg_reg      <= '0;
            sig_avg_reg       <= '0;
            fast_sum_reg      <= '0;
            slow_sum_reg      <= '0;
            sig_sum_reg       <= '0;
            sample_count_reg  <= '0;
            macd_count_reg    <= '0;
            fast_period_reg   <= FAST_PERIOD_RST;
            slow_period_reg   <= SLOW_PERIOD_RST;
            signal_period_reg <= SIGNAL_PERIOD_RST;
            fast_alpha_reg    <= FAST_ALPHA_RST;
            slow_alpha_reg    <= SLOW_ALPHA_RST;
            signal_alpha_reg  <= SIGNAL_ALPHA_RST;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            fast_avg_reg     <= fast_avg_next;
            slow_avg_reg     <= slow_avg_next;
            sig_avg_reg      <= sig_avg_next;
            fast_sum_reg     <= fast_sum_next;
            slow_sum_reg     <= slow_sum_next;
            sig_sum_reg      <= sig_sum_next;
            sample_count_reg <= sample_count_next;
            macd_count_reg   <= macd_count_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FAST_PERIOD:   fast_period_reg   <= cfg_data[PERIOD_W-1:0];
                    REG_SLOW_PERIOD:   slow_period_reg   <= cfg_data[PERIOD_W-1:0];
                    REG_SIGNAL_PERIOD: signal_period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_FAST_ALPHA:    fast_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                    REG_SLOW_ALPHA:    slow_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                    REG_SIGNAL_ALPHA:  signal_alpha_reg  <= cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        macd_reg   <= macd_next;
        result_reg <= result_next;
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> state_reg == S_FAST)
        else $error("accepted sample did not start the fast average update");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_rsp.done |-> (state_reg == S_FAST_W || state_reg == S_SLOW_W
                           || state_reg == S_SIG_W))
        else $error("shared unit finished outside a wait state");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        macd_count_reg <= sample_count_reg)
        else $error("MACD count ran ahead of the sample count");

    a_valid_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.signal_valid |-> result_reg.macd_valid)
        else $error("signal line flagged valid without a valid MACD line");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && (!result_valid_reg || result_ready)
        |=> state_reg == S_IDLE && result_valid_reg)
        else $error("result was not loaded when the output register was free");

endmodule
